// File: design/glyph_cell_pixel_blender_top_assert.svh
// ----------------------------------------------------------------------------
// Glyph cell pixel blender assertion macros
// Shorthand for the clocked implication checks used at the top level.
// ----------------------------------------------------------------------------
`ifndef GLYPH_CELL_PIXEL_BLENDER_TOP_ASSERT_SVH
`define GLYPH_CELL_PIXEL_BLENDER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GCPB_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GCPB_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/gcpb_pkg.sv
// ----------------------------------------------------------------------------
// Glyph cell pixel blender package
// Shared types, register indexes and constants of the pixel blender.
// ----------------------------------------------------------------------------
package gcpb_pkg;

    // Configuration register indexes (byte address is four times the index).
    localparam int        CFG_ADDR_W       = 5;
    localparam logic [2:0] REG_FRAME_WIDTH   = 3'd0;
    localparam logic [2:0] REG_CELL_WIDTH_PX = 3'd1;
    localparam logic [2:0] REG_CELL_HEIGHT   = 3'd2;
    localparam logic [2:0] REG_OPACITY       = 3'd3;
    localparam logic [2:0] REG_BUFFER_AGE    = 3'd4;
    localparam logic [2:0] REG_FORCE_REDRAW  = 3'd5;

    // Field widths of the item streams.
    localparam int PIX_ADDR_W = 26;
    localparam int IN_DATA_W  = 112;
    localparam int OUT_DATA_W = 64;

    // Partial address widths, sized for the largest supported cell.
    localparam int ROWB_W = 17;
    localparam int COLO_W = 18;

    // Queue between the front and the back.
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;

    // Colour constants.
    localparam logic [7:0]  FG_ALPHA = 8'hff;
    localparam logic [31:0] RB_MASK  = 32'h00ff00ff;
    localparam logic [31:0] G_MASK   = 32'h0000ff00;
    localparam logic [23:0] RB_KEEP  = 24'hff00ff;
    localparam logic [23:0] G_KEEP   = 24'h00ff00;

    // How the back end forms the pixel value.
    typedef enum logic [1:0] {
        KIND_BG    = 2'd0,
        KIND_FG    = 2'd1,
        KIND_BLEND = 2'd2
    } t_kind;

    // Configuration register set.
    typedef struct packed {
        logic [13:0] frame_width;
        logic [6:0]  cell_width_px;
        logic [7:0]  cell_height_px;
        logic [7:0]  opacity;
        logic [31:0] buffer_age;
        logic        force_redraw;
    } t_cfg;

    // One input item, unpacked.
    typedef struct packed {
        logic [9:0]  cell_col;
        logic [8:0]  cell_row;
        logic [1:0]  cell_width;
        logic        inverse;
        logic        blank_cell;
        logic [23:0] fg_rgb;
        logic [23:0] bg_rgb;
        logic [7:0]  coverage;
        logic [31:0] cell_age;
    } t_pixel;

    // Classified work handed from the front to the back.
    typedef struct packed {
        logic [ROWB_W-1:0] row_base;
        logic [COLO_W-1:0] col_off;
        logic [23:0]       bg_rgb;
        logic [23:0]       fg_rgb;
        logic [7:0]        coverage;
        t_kind             kind;
        logic              done;
    } t_job;

endpackage

// File: design/gcpb_fifo.sv
// ----------------------------------------------------------------------------
// Glyph cell pixel blender job queue
// Small first-in first-out queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module gcpb_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  gcpb_pkg::t_job  i_data,
    output logic            o_full,
    output logic            o_valid,
    input  logic            i_pop,
    output gcpb_pkg::t_job  o_data
);

    gcpb_pkg::t_job                  r_mem [gcpb_pkg::Q_DEPTH];
    logic [gcpb_pkg::Q_PTR_W-1:0]   r_wr_ptr;
    logic [gcpb_pkg::Q_PTR_W-1:0]   r_rd_ptr;
    logic [gcpb_pkg::Q_PTR_W:0]     r_count;

    // Status and head of the queue.
    assign o_full  = (r_count == (gcpb_pkg::Q_PTR_W+1)'(gcpb_pkg::Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: design/gcpb_front.sv
// ----------------------------------------------------------------------------
// Glyph cell pixel blender front end
// Accepts pixel items, tracks the position inside the cell, drops skipped
// cells and forms the partial address and colour selection of each item.
// ----------------------------------------------------------------------------
module gcpb_front #(
    parameter int MAX_CELL_PX = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gcpb_pkg::t_cfg    i_cfg,
    input  logic              i_valid,
    output logic              o_ready,
    input  gcpb_pkg::t_pixel  i_pixel,
    input  logic              i_full,
    output logic              o_push,
    output gcpb_pkg::t_job    o_job
);

    localparam int CNT_W = $clog2(2 * MAX_CELL_PX);
    localparam int CW_W  = $clog2(MAX_CELL_PX + 1);
    localparam int CH_W  = $clog2(2 * MAX_CELL_PX + 1);

    logic [CNT_W-1:0] r_pix_col;
    logic [CNT_W-1:0] r_pix_row;
    logic [CNT_W-1:0] n_pix_col;
    logic [CNT_W-1:0] n_pix_row;

    logic             w_accept;
    logic             w_draw;
    logic [1:0]       w_cw;
    logic [CW_W-1:0]  w_cwpx;
    logic [CH_W-1:0]  w_chpx;
    logic [CH_W-1:0]  w_rowpx;
    logic [31:0]      w_col_inc;
    logic [31:0]      w_row_inc;
    logic             w_last_col;
    logic             w_done;

    assign o_ready  = !i_full;
    assign w_accept = i_valid && o_ready;

    // Effective cell geometry: zero counts as one, oversize is clamped.
    always_comb begin
        case (i_pixel.cell_width)
            2'd0:    w_cw = 2'd1;
            2'd3:    w_cw = 2'd2;
            default: w_cw = i_pixel.cell_width;
        endcase
        if (i_cfg.cell_width_px == '0) begin
            w_cwpx = CW_W'(1);
        end else if (32'(i_cfg.cell_width_px) > 32'(MAX_CELL_PX)) begin
            w_cwpx = CW_W'(MAX_CELL_PX);
        end else begin
            w_cwpx = CW_W'(i_cfg.cell_width_px);
        end
        if (i_cfg.cell_height_px == '0) begin
            w_chpx = CH_W'(1);
        end else if (32'(i_cfg.cell_height_px) > 32'(2 * MAX_CELL_PX)) begin
            w_chpx = CH_W'(2 * MAX_CELL_PX);
        end else begin
            w_chpx = CH_W'(i_cfg.cell_height_px);
        end
        w_rowpx = CH_W'(w_cw) * CH_W'(w_cwpx);
    end

    // Wrap tests of the position counters.
    assign w_col_inc  = 32'(r_pix_col) + 32'd1;
    assign w_row_inc  = 32'(r_pix_row) + 32'd1;
    assign w_last_col = (w_col_inc >= 32'(w_rowpx));
    assign w_done     = w_last_col && (w_row_inc >= 32'(w_chpx));

    // Skipped cells still advance the counters but yield no item.
    assign w_draw = !((i_pixel.cell_age <= i_cfg.buffer_age) && !i_cfg.force_redraw);
    assign o_push = w_accept && w_draw;

    // Next position inside the cell.
    always_comb begin
        n_pix_col = r_pix_col;
        n_pix_row = r_pix_row;
        if (w_accept) begin
            if (w_last_col) begin
                n_pix_col = '0;
                n_pix_row = w_done ? '0 : CNT_W'(w_row_inc);
            end else begin
                n_pix_col = CNT_W'(w_col_inc);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pix_col <= '0;
            r_pix_row <= '0;
        end else begin
            r_pix_col <= n_pix_col;
            r_pix_row <= n_pix_row;
        end
    end

    // Partial address, colour swap and classification of the pixel.
    always_comb begin
        o_job.row_base = gcpb_pkg::ROWB_W'(i_pixel.cell_row) * gcpb_pkg::ROWB_W'(w_chpx)
                       + gcpb_pkg::ROWB_W'(r_pix_row);
        o_job.col_off  = gcpb_pkg::COLO_W'(i_pixel.cell_col) * gcpb_pkg::COLO_W'(w_cwpx)
                       + gcpb_pkg::COLO_W'(r_pix_col);
        if (i_pixel.inverse) begin
            o_job.bg_rgb = i_pixel.fg_rgb;
            o_job.fg_rgb = i_pixel.bg_rgb;
        end else begin
            o_job.bg_rgb = i_pixel.bg_rgb;
            o_job.fg_rgb = i_pixel.fg_rgb;
        end
        o_job.coverage = i_pixel.coverage;
        if (i_pixel.blank_cell || (i_pixel.coverage == 8'h00)) begin
            o_job.kind = gcpb_pkg::KIND_BG;
        end else if (i_pixel.coverage == 8'hff) begin
            o_job.kind = gcpb_pkg::KIND_FG;
        end else begin
            o_job.kind = gcpb_pkg::KIND_BLEND;
        end
        o_job.done = w_done;
    end

endmodule

// File: design/gcpb_back.sv
// ----------------------------------------------------------------------------
// Glyph cell pixel blender back end
// Finishes the framebuffer address, blends the colours and holds the result
// item in an output register until it is taken.
// ----------------------------------------------------------------------------
module gcpb_back #(
    parameter int ADDR_BITS = 26
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  gcpb_pkg::t_cfg                     i_cfg,
    input  logic                               i_valid,
    input  gcpb_pkg::t_job                     i_job,
    output logic                               o_pop,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [gcpb_pkg::PIX_ADDR_W-1:0]    o_addr,
    output logic [31:0]                        o_value,
    output logic                               o_done
);

    localparam logic [32:0] ADDR_MASK = (33'd1 << ADDR_BITS) - 33'd1;

    logic                              r_valid;
    logic [gcpb_pkg::PIX_ADDR_W-1:0]   r_addr;
    logic [31:0]                       r_value;
    logic                              r_done;

    logic [30:0] w_prod;
    logic [31:0] w_addr;
    logic [31:0] w_bg;
    logic [31:0] w_fg;
    logic [15:0] w_alpha;
    logic [31:0] w_rb_bg;
    logic [31:0] w_rb_p;
    logic [31:0] w_rb_n;
    logic [31:0] w_g_bg;
    logic [31:0] w_g_p;
    logic [31:0] w_g_n;
    logic [31:0] w_blend;
    logic [31:0] w_value;

    // Row base times the stride, plus the column offset, wrapped to ADDR_BITS.
    assign w_prod = 31'(i_job.row_base) * 31'(i_cfg.frame_width);
    assign w_addr = (32'(w_prod) + 32'(i_job.col_off)) & ADDR_MASK[31:0];

    // Packed blend; only the low bits of each wrapped product reach the result.
    always_comb begin
        w_bg    = {i_cfg.opacity, i_job.bg_rgb};
        w_fg    = {gcpb_pkg::FG_ALPHA, i_job.fg_rgb};
        w_alpha = {i_cfg.opacity, 8'h00} + {i_job.coverage, 8'h00}
                - 16'(i_job.coverage) * 16'(i_cfg.opacity);
        w_rb_bg = w_bg & gcpb_pkg::RB_MASK;
        w_rb_p  = ((w_fg & gcpb_pkg::RB_MASK) - w_rb_bg) * 32'(i_job.coverage);
        w_rb_n  = w_rb_bg + (w_rb_p >> 8);
        w_g_bg  = w_bg & gcpb_pkg::G_MASK;
        w_g_p   = ((w_fg & gcpb_pkg::G_MASK) - w_g_bg) * 32'(i_job.coverage);
        w_g_n   = w_g_bg + (w_g_p >> 8);
        w_blend = {w_alpha[15:8],
                   (w_rb_n[23:0] & gcpb_pkg::RB_KEEP) | (w_g_n[23:0] & gcpb_pkg::G_KEEP)};
    end

    // Pixel value by classification.
    always_comb begin
        case (i_job.kind)
            gcpb_pkg::KIND_BG:    w_value = w_bg;
            gcpb_pkg::KIND_FG:    w_value = w_fg;
            gcpb_pkg::KIND_BLEND: w_value = w_blend;
            default:              w_value = w_bg;
        endcase
    end

    // Take a job whenever the output register is empty or being drained.
    assign o_pop = i_valid && (!r_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_addr  <= w_addr[gcpb_pkg::PIX_ADDR_W-1:0];
            r_value <= w_value;
            r_done  <= i_job.done;
        end
    end

    assign o_valid = r_valid;
    assign o_addr  = r_addr;
    assign o_value = r_value;
    assign o_done  = r_done;

endmodule

// File: design/glyph_cell_pixel_blender_top.sv
// The blender takes one glyph-coverage pixel per item and can sustain one item
// per clock unless the master side stalls: an accepted item is classified in
// the front end in the cycle it arrives, waits in a four-entry queue, and is
// held in the back end's output register until taken. The rate is set by the
// back end, whose stride multiplier and blend multipliers each finish one pixel
// per cycle. Pixels of a skipped cell advance the in-cell position but
// produce no result item. Configuration is written through the register
// port only while no item is in flight, a user rule the block does not enforce.
// ----------------------------------------------------------------------------
// Glyph cell pixel blender top level
// Stream ports, configuration registers and the front, queue and back ends.
// ----------------------------------------------------------------------------
`include "glyph_cell_pixel_blender_top_assert.svh"

module glyph_cell_pixel_blender_top #(
    parameter int MAX_CELL_PX = 64,
    parameter int ADDR_BITS   = 26
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Input items.
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // cell_col[9:0], cell_row[18:10], cell_width[20:19], fg_rgb[44:21],
    // bg_rgb[68:45], coverage[76:69], cell_age[108:77], zero fill above
    input  logic [gcpb_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // inverse[0], blank_cell[1]
    input  logic [1:0]                          s_axis_tuser,
    // Result items.
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // pixel_address[25:0], pixel_value[57:26], zero fill above
    output logic [gcpb_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // cell_done
    output logic                                m_axis_tlast,
    // Configuration port.
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [gcpb_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    gcpb_pkg::t_cfg                     r_cfg;
    gcpb_pkg::t_pixel                   w_pixel;
    gcpb_pkg::t_job                     w_push_job;
    gcpb_pkg::t_job                     w_q_job;
    logic                               w_push;
    logic                               w_q_full;
    logic                               w_q_valid;
    logic                               w_pop;
    logic                               w_cfg_wr;
    logic [2:0]                         w_reg_idx;
    logic [gcpb_pkg::PIX_ADDR_W-1:0]    w_out_addr;
    logic [31:0]                        w_out_value;

    // Register port: always ready, written in the access cycle.
    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_reg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_width    <= 14'd640;
            r_cfg.cell_width_px  <= 7'd8;
            r_cfg.cell_height_px <= 8'd16;
            r_cfg.opacity        <= 8'd255;
            r_cfg.buffer_age     <= 32'd0;
            r_cfg.force_redraw   <= 1'b1;
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                gcpb_pkg::REG_FRAME_WIDTH:   r_cfg.frame_width    <= pwdata[13:0];
                gcpb_pkg::REG_CELL_WIDTH_PX: r_cfg.cell_width_px  <= pwdata[6:0];
                gcpb_pkg::REG_CELL_HEIGHT:   r_cfg.cell_height_px <= pwdata[7:0];
                gcpb_pkg::REG_OPACITY:       r_cfg.opacity        <= pwdata[7:0];
                gcpb_pkg::REG_BUFFER_AGE:    r_cfg.buffer_age     <= pwdata;
                gcpb_pkg::REG_FORCE_REDRAW:  r_cfg.force_redraw   <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        case (w_reg_idx)
            gcpb_pkg::REG_FRAME_WIDTH:   prdata = 32'(r_cfg.frame_width);
            gcpb_pkg::REG_CELL_WIDTH_PX: prdata = 32'(r_cfg.cell_width_px);
            gcpb_pkg::REG_CELL_HEIGHT:   prdata = 32'(r_cfg.cell_height_px);
            gcpb_pkg::REG_OPACITY:       prdata = 32'(r_cfg.opacity);
            gcpb_pkg::REG_BUFFER_AGE:    prdata = r_cfg.buffer_age;
            gcpb_pkg::REG_FORCE_REDRAW:  prdata = 32'(r_cfg.force_redraw);
            default:                     prdata = 32'd0;
        endcase
    end

    // Unpack the input item.
    always_comb begin
        w_pixel.cell_col   = s_axis_tdata[9:0];
        w_pixel.cell_row   = s_axis_tdata[18:10];
        w_pixel.cell_width = s_axis_tdata[20:19];
        w_pixel.fg_rgb     = s_axis_tdata[44:21];
        w_pixel.bg_rgb     = s_axis_tdata[68:45];
        w_pixel.coverage   = s_axis_tdata[76:69];
        w_pixel.cell_age   = s_axis_tdata[108:77];
        w_pixel.inverse    = s_axis_tuser[0];
        w_pixel.blank_cell = s_axis_tuser[1];
    end

    gcpb_front #(
        .MAX_CELL_PX (MAX_CELL_PX)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_pixel (w_pixel),
        .i_full  (w_q_full),
        .o_push  (w_push),
        .o_job   (w_push_job)
    );

    gcpb_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_job),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .i_pop   (w_pop),
        .o_data  (w_q_job)
    );

    gcpb_back #(
        .ADDR_BITS (ADDR_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (w_q_valid),
        .i_job   (w_q_job),
        .o_pop   (w_pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_addr  (w_out_addr),
        .o_value (w_out_value),
        .o_done  (m_axis_tlast)
    );

    // Pack the result item.
    assign m_axis_tdata = {6'd0, w_out_value, w_out_addr};

    // The front never writes into a full queue.
    `GCPB_ASSERT_IMP(a_no_push_full, i_clk, i_rst_n, w_push, !w_q_full, "push into full queue")
    // With forced redraw every accepted item is queued.
    `GCPB_ASSERT_IMP(a_redraw_queues, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready && r_cfg.force_redraw, w_push, "redrawn item not queued")
    // A job taken from the queue shows up as a result item next cycle.
    `GCPB_ASSERT_NXT(a_pop_shows, i_clk, i_rst_n, w_pop, m_axis_tvalid, "popped job missing at output")

endmodule
